>>> design/escape_sequence_decoder_top_assert.svh
// Assertion macros shared by the escape sequence decoder checkers.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// Check a same-cycle implication, disabled while reset is held
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication on the next cycle, disabled while reset is held
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/esd_pkg.sv
// Package for the escape sequence decoder: phase type, result packet,
// character constants and the small character classification functions.
package esd_pkg;

	// Result packet limits: up to four result beats per input beat
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned IDX_W = $clog2(MAX_RESULTS);
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] BSLASH = 8'h5C;
	localparam logic [7:0] SMALL_X = 8'h78;
	localparam logic [7:0] BIG_X = 8'h58;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC = 2'd1,
		PH_HEX1 = 2'd2,
		PH_HEX2 = 2'd3
	} esd_phase_t;

	// All result beats caused by one input beat
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [IDX_W-1:0] last_idx;
		logic bare;
		logic eos;
	} esd_pkt_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
			(c >= "A" && c <= "F");
	endfunction

	// Value of a hex digit; letters sit at 0x41 or 0x61, so low nibble plus 9
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

	// Map a simple escape letter; bit 8 flags a hit
	function automatic logic [8:0] esc_lookup(input logic [7:0] c);
		logic [8:0] r;
		r = '0;
		unique case (c)
			BSLASH: r = {1'b1, BSLASH};
			"a": r = {1'b1, 8'h07};
			"b": r = {1'b1, 8'h08};
			"c": r = {1'b1, 8'h01};
			"f": r = {1'b1, 8'h0C};
			"n": r = {1'b1, 8'h0A};
			"t": r = {1'b1, 8'h09};
			"v": r = {1'b1, 8'h0B};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/esd_front.sv
// Front end of the escape sequence decoder: tracks the decode phase and
// builds the result packet for each input beat. Uses esd_pkg.
module esd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_in,
	input  logic             last_in,
	output logic             push,
	output esd_pkg::esd_pkt_t pkt
);
	import esd_pkg::*;

	esd_phase_t phase_q, phase_mid, phase_d;
	logic [7:0] held_q, held_mid, held_d;
	logic c_hex;

	assign c_hex = is_hex(char_in);

	// Phase after the byte itself, before the end-of-string flush
	always_comb begin
		phase_mid = phase_q;
		held_mid = held_q;
		unique case (phase_q)
			PH_PLAIN: begin
				if (char_in == BSLASH) phase_mid = PH_ESC;
			end
			PH_ESC: begin
				phase_mid = (char_in == SMALL_X || char_in == BIG_X) ? PH_HEX1 : PH_PLAIN;
			end
			PH_HEX1: begin
				if (c_hex) begin
					held_mid = char_in;
					phase_mid = PH_HEX2;
				end else begin
					phase_mid = (char_in == BSLASH) ? PH_ESC : PH_PLAIN;
				end
			end
			PH_HEX2: begin
				held_mid = '0;
				phase_mid = (!c_hex && char_in == BSLASH) ? PH_ESC : PH_PLAIN;
			end
		endcase
	end

	// Next state: the last byte of a string returns to plain text
	always_comb begin
		phase_d = last_in ? PH_PLAIN : phase_mid;
		held_d = last_in ? 8'h00 : held_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			held_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q <= held_d;
		end
	end

	// Outputs: collect the result bytes for this beat in order
	always_comb begin
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [CNT_W-1:0] n;
		logic [8:0] esc;
		bytes = '0;
		n = '0;
		esc = esc_lookup(char_in);
		unique case (phase_q)
			PH_PLAIN: begin
				if (char_in != BSLASH) begin
					bytes[n[IDX_W-1:0]] = char_in;
					n = n + 1'b1;
				end
			end
			PH_ESC: begin
				if (esc[8]) begin
					bytes[n[IDX_W-1:0]] = esc[7:0];
					n = n + 1'b1;
				end
			end
			PH_HEX1: begin
				if (!c_hex) begin
					bytes[n[IDX_W-1:0]] = BSLASH;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = SMALL_X;
					n = n + 1'b1;
					if (char_in != BSLASH) begin
						bytes[n[IDX_W-1:0]] = char_in;
						n = n + 1'b1;
					end
				end
			end
			PH_HEX2: begin
				if (c_hex) begin
					bytes[n[IDX_W-1:0]] = {hex_value(held_q), hex_value(char_in)};
					n = n + 1'b1;
				end else begin
					// held digit is a hex digit, so it always passes through
					bytes[n[IDX_W-1:0]] = BSLASH;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = SMALL_X;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = held_q;
					n = n + 1'b1;
					if (char_in != BSLASH) begin
						bytes[n[IDX_W-1:0]] = char_in;
						n = n + 1'b1;
					end
				end
			end
		endcase

		// Flush an open escape at the end of the string
		if (last_in) begin
			unique case (phase_mid)
				PH_PLAIN: begin
				end
				PH_ESC: begin
					bytes[n[IDX_W-1:0]] = BSLASH;
					n = n + 1'b1;
				end
				PH_HEX1: begin
					bytes[n[IDX_W-1:0]] = BSLASH;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = SMALL_X;
					n = n + 1'b1;
				end
				PH_HEX2: begin
					bytes[n[IDX_W-1:0]] = BSLASH;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = SMALL_X;
					n = n + 1'b1;
					bytes[n[IDX_W-1:0]] = held_mid;
					n = n + 1'b1;
				end
			endcase
		end

		pkt.bytes = bytes;
		pkt.bare = last_in && (n == '0);
		pkt.eos = last_in;
		pkt.last_idx = (n == '0) ? '0 : IDX_W'(n - 1'b1);
		push = accept && ((n != '0) || last_in);
	end

endmodule

>>> design/esd_queue.sv
// Short packet queue between the decoder front and back.
// Uses esd_pkg for the packet type.
module esd_queue #(
	parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esd_pkg::esd_pkt_t push_pkt,
	output logic             ready,
	input  logic             pop,
	output logic             head_valid,
	output esd_pkg::esd_pkt_t head_pkt
);
	import esd_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	esd_pkt_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pkt = slots_q[rd_ptr_q];

	// Store a packet on push
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_pkt;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> design/esd_back.sv
// Back end of the escape sequence decoder: sends the packet at the head
// of the queue one result beat at a time. Uses esd_pkg.
module esd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  esd_pkg::esd_pkt_t head_pkt,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       char_out,
	output logic             char_valid,
	output logic             end_of_string
);
	import esd_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic at_last;

	assign at_last = (idx_q == head_pkt.last_idx);
	assign out_valid = head_valid;
	assign char_out = head_pkt.bytes[idx_q];
	assign char_valid = !head_pkt.bare;
	assign end_of_string = head_pkt.eos && at_last;
	assign pop = out_valid && out_ready && at_last;

	// Step through the packet; drop it after its last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= at_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

>>> design/escape_sequence_decoder_top.sv
// Backslash escape decoder for a byte stream.
//
// Input channel (in_valid/in_ready): one source byte per beat in char_in,
// with last_in set on the final byte of a string.
// Output channel (out_valid/out_ready): one decoded byte per beat in
// char_out with char_valid; end_of_string marks the last result caused by
// the final byte, and a bare end marker has char_valid low.
// Results of an input beat are registered in the queue on the way out.
// Throughput: one input beat per cycle while out_ready is high and each
// byte yields at most one result; a byte yielding k results holds the
// output for k beats, as the result serializer sends one beat per cycle.
// The front decodes each byte in its cycle and writes a packet of up to
// four results into a QDEPTH-entry queue; the back drains it.
// Reset clears the decode phase to plain text and empties the queue.
// When the receiver stalls, the queue fills and in_ready drops until the
// back frees an entry.
// Uses esd_pkg, esd_front, esd_queue and esd_back.
module escape_sequence_decoder_top #(
	parameter int unsigned QDEPTH = esd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       char_valid,
	output logic       end_of_string
);
	import esd_pkg::*;

	esd_pkt_t push_pkt, head_pkt;
	logic push, pop, head_valid, accept;

	assign accept = in_valid && in_ready;

	esd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.char_in (char_in),
		.last_in (last_in),
		.push    (push),
		.pkt     (push_pkt)
	);

	esd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.ready      (in_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_pkt   (head_pkt)
	);

	esd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_pkt      (head_pkt),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.char_valid    (char_valid),
		.end_of_string (end_of_string)
	);

endmodule

>>> design/esd_checker.sv
// Port-level checks for the escape sequence decoder, bound to its top.
// Uses the macros of escape_sequence_decoder_top_assert.svh.
`include "escape_sequence_decoder_top_assert.svh"

module esd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] char_in,
	input logic       last_in,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic       char_valid,
	input logic       end_of_string
);

	// A stalled result beat holds
	`ESD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(char_valid) && $stable(end_of_string), "stalled result beat changed")

	// A stalled input beat holds
	`ESD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(char_in) && $stable(last_in), "stalled input beat changed")

	// A bare marker only closes a string
	`ESD_ASSERT_NOW(a_bare_eos, out_valid && !char_valid, end_of_string, "bare marker without end of string")

	// A bare marker carries a zero byte
	`ESD_ASSERT_NOW(a_bare_zero, out_valid && !char_valid, char_out == 8'h00, "bare marker with nonzero byte")

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (.*);
